// ===== design/kwh_pkg.sv =====
// kwh_pkg: shared constants, codes and types of the k-mer window histogram
// used by every module of the block; depends on nothing
`default_nettype none

package kwh_pkg;

    // fixed field layout
    localparam int CODE_BITS    = 3;
    localparam int WIN_BITS     = 12;
    localparam int BIN_COUNT    = 4096;
    localparam int LETTER_SLOTS = 8;
    localparam int QUEUE_DEPTH  = 4;

    // port widths
    localparam int CMD_W       = 2;
    localparam int SYMBOL_W    = 8;
    localparam int S_TDATA_W   = 24;
    localparam int RESULT_W    = 32;
    localparam int M_TDATA_W   = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int SIZE_W      = 4;
    localparam int KLEN_W      = 3;

    // parameter defaults
    localparam int ALPHABET_MAX_DEF = 8;
    localparam int K_MAX_DEF        = 4;
    localparam int COUNT_WIDTH_DEF  = 32;

    // reset values of the configuration registers
    localparam logic [SIZE_W-1:0]     SIZE_RESET    = 4'd4;
    localparam logic [CFG_DATA_W-1:0] LETTERS_RESET = 64'd1414022977;
    localparam logic [KLEN_W-1:0]     KLEN_RESET    = 3'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SYMBOL = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } kwh_cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SIZE    = 2'd0,
        CFG_LETTERS = 2'd1,
        CFG_KLEN    = 2'd2
    } kwh_cfg_t;

    // work handed from the front to the back
    typedef enum logic [1:0] {
        OP_INC     = 2'd0,
        OP_FOREIGN = 2'd1,
        OP_READ    = 2'd2,
        OP_CLEAR   = 2'd3
    } kwh_op_t;

    typedef struct packed {
        kwh_op_t             op;
        logic [WIN_BITS-1:0] addr;
    } kwh_entry_t;

    typedef struct packed {
        logic clearing;
    } kwh_back_status_t;

    typedef struct packed {
        logic full;
    } kwh_queue_status_t;

    typedef enum logic {
        BK_CLEAR = 1'b0,
        BK_RUN   = 1'b1
    } kwh_back_state_t;

endpackage : kwh_pkg

`default_nettype wire

// ===== design/kwh_front.sv =====
// kwh_front: accepts stream words and configuration writes, maps letters,
// keeps the letter window and issues histogram work; depends on kwh_pkg
`default_nettype none

module kwh_front
    import kwh_pkg::*;
#(
    parameter int ALPHABET_MAX = ALPHABET_MAX_DEF,
    parameter int K_MAX        = K_MAX_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic [CMD_W-1:0]       s_tuser,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire kwh_back_status_t       back_status,
    input  wire kwh_queue_status_t      queue_status,
    output logic                        push,
    output kwh_entry_t                  push_entry
);

    localparam int KW = $clog2(K_MAX + 1);

    logic [SIZE_W-1:0]     size_reg;
    logic [CFG_DATA_W-1:0] letters_reg;
    logic [KLEN_W-1:0]     klen_reg;

    logic [WIN_BITS-1:0] codes_reg, codes_next;
    logic [KW-1:0]       seen_reg, seen_next;
    logic [KW-1:0]       age_reg, age_next;

    logic [SIZE_W-1:0]    n_eff;
    logic [KW-1:0]        k_eff;
    logic [WIN_BITS-1:0]  win_mask;
    logic [CODE_BITS-1:0] code;
    logic                 found;
    logic [KW-1:0]        seen_inc;
    logic [KW-1:0]        age_set;
    logic                 accept;
    logic [SYMBOL_W-1:0]  symbol;
    logic [WIN_BITS-1:0]  read_index;
    logic                 blank;

    assign s_tready   = !queue_status.full && !back_status.clearing;
    assign cfg_ready  = 1'b1;
    assign accept     = s_tvalid && s_tready;
    assign symbol     = s_tdata[SYMBOL_W-1:0];
    assign read_index = s_tdata[SYMBOL_W +: WIN_BITS];
    assign blank      = (symbol == 8'h20) || (symbol >= 8'h09 && symbol <= 8'h0d);

    // effective alphabet size and window length
    always_comb begin
        n_eff = size_reg;
        if (int'(n_eff) > ALPHABET_MAX) n_eff = SIZE_W'(ALPHABET_MAX);
        if (int'(n_eff) > LETTER_SLOTS) n_eff = SIZE_W'(LETTER_SLOTS);
        k_eff = KW'(klen_reg);
        if (klen_reg == '0) k_eff = KW'(1);
        if (int'(klen_reg) > K_MAX) k_eff = KW'(K_MAX);
        win_mask = WIN_BITS'((64'd1 << (CODE_BITS * int'(k_eff))) - 64'd1);
    end

    // lowest matching letter wins
    always_comb begin
        code  = '0;
        found = 1'b0;
        for (int i = LETTER_SLOTS - 1; i >= 0; i--) begin
            if (i < int'(n_eff) && letters_reg[8*i +: 8] == symbol) begin
                code  = CODE_BITS'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        codes_next = codes_reg;
        seen_next  = seen_reg;
        age_next   = age_reg;
        push       = 1'b0;
        push_entry = '{op: OP_INC, addr: read_index};
        seen_inc   = (int'(seen_reg) < K_MAX) ? seen_reg + KW'(1) : seen_reg;
        age_set    = found ? age_reg : k_eff;

        if (cfg_valid && cfg_ready && cfg_index == CFG_KLEN) begin
            codes_next = '0;
            seen_next  = '0;
            age_next   = '0;
        end

        if (accept) begin
            unique case (kwh_cmd_t'(s_tuser))
                CMD_SYMBOL: begin
                    if (!blank) begin
                        codes_next = WIN_BITS'({codes_reg, code}) & win_mask;
                        seen_next  = seen_inc;
                        age_next   = (age_set != '0) ? age_set - KW'(1) : '0;
                        if (seen_inc >= k_eff) begin
                            push            = 1'b1;
                            push_entry.op   = (age_set != '0) ? OP_FOREIGN : OP_INC;
                            push_entry.addr = codes_next;
                        end
                    end
                end
                CMD_READ: begin
                    push          = 1'b1;
                    push_entry.op = OP_READ;
                end
                CMD_CLEAR: begin
                    push          = 1'b1;
                    push_entry.op = OP_CLEAR;
                    codes_next    = '0;
                    seen_next     = '0;
                    age_next      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= SIZE_RESET;
            letters_reg <= LETTERS_RESET;
            klen_reg    <= KLEN_RESET;
            codes_reg   <= '0;
            seen_reg    <= '0;
            age_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (kwh_cfg_t'(cfg_index))
                    CFG_SIZE:    size_reg    <= cfg_data[SIZE_W-1:0];
                    CFG_LETTERS: letters_reg <= cfg_data;
                    CFG_KLEN:    klen_reg    <= cfg_data[KLEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            codes_reg <= codes_next;
            seen_reg  <= seen_next;
            age_reg   <= age_next;
        end
    end

endmodule : kwh_front

`default_nettype wire

// ===== design/kwh_queue.sv =====
// kwh_queue: short first-in first-out buffer of work between front and back
// depends on kwh_pkg
`default_nettype none

module kwh_queue
    import kwh_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire kwh_entry_t push_entry,
    input  wire logic       pop,
    output logic            head_valid,
    output kwh_entry_t      head_entry,
    output kwh_queue_status_t status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    kwh_entry_t    entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_pop;

    assign head_valid  = (fill_reg != '0);
    assign head_entry  = entries_reg[rd_ptr_reg];
    assign status.full = (fill_reg == CW'(QUEUE_DEPTH));
    assign do_pop      = pop && head_valid;

    always_comb begin
        fill_next = fill_reg;
        if (push && !do_pop) fill_next = fill_reg + CW'(1);
        if (!push && do_pop) fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule : kwh_queue

`default_nettype wire

// ===== design/kwh_back.sv =====
// kwh_back: histogram memory with read-modify-write and forwarding, foreign
// counter, clearing sweep and result register; depends on kwh_pkg
`default_nettype none

module kwh_back
    import kwh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 head_valid,
    input  wire kwh_entry_t           head_entry,
    output logic                      pop,
    output kwh_back_status_t          status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    logic [COUNT_WIDTH-1:0] hist_mem [BIN_COUNT];

    kwh_back_state_t state_reg, state_next;
    logic [WIN_BITS-1:0] clr_cnt_reg, clr_cnt_next;

    // execute stage: one op with its bin value read from memory
    logic                   s1_valid_reg;
    kwh_op_t                s1_op_reg;
    logic [WIN_BITS-1:0]    s1_addr_reg;
    logic [COUNT_WIDTH-1:0] s1_data_reg;

    // write made in the cycle the current op was read
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [WIN_BITS-1:0]    fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic [COUNT_WIDTH-1:0] foreign_reg, foreign_next;

    logic                out_valid_reg;
    logic [RESULT_W-1:0] out_count_reg, out_foreign_reg;

    logic [COUNT_WIDTH-1:0] operand, inc_val;
    logic                   out_free, s1_advance, s1_hold, s1_free, load_out;
    logic                   mem_we;
    logic [WIN_BITS-1:0]    mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    assign status.clearing = (state_reg == BK_CLEAR);
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {out_foreign_reg, out_count_reg};

    always_comb begin
        operand = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : s1_data_reg;
        inc_val = (operand == COUNT_TOP) ? operand : operand + COUNT_WIDTH'(1);
        out_free   = !out_valid_reg || m_tready;
        s1_advance = s1_valid_reg && (s1_op_reg != OP_READ || out_free);
        s1_hold    = s1_valid_reg && !s1_advance;
        s1_free    = !s1_valid_reg || s1_advance;
        load_out   = s1_advance && s1_op_reg == OP_READ;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = s1_addr_reg;
        mem_wdata    = inc_val;
        foreign_next = foreign_reg;

        unique case (state_reg)
            BK_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + WIN_BITS'(1);
                if (clr_cnt_reg == WIN_BITS'(BIN_COUNT - 1)) state_next = BK_RUN;
            end
            BK_RUN: begin
                pop = head_valid && s1_free && !(s1_valid_reg && s1_op_reg == OP_CLEAR);
                if (s1_advance) begin
                    case (s1_op_reg)
                        OP_INC: mem_we = 1'b1;
                        OP_FOREIGN: begin
                            foreign_next = (foreign_reg == COUNT_TOP) ? foreign_reg
                                                                      : foreign_reg + COUNT_WIDTH'(1);
                        end
                        OP_CLEAR: begin
                            foreign_next = '0;
                            clr_cnt_next = '0;
                            state_next   = BK_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: state_next = BK_CLEAR;
        endcase

        fwd_valid_next = pop && mem_we && state_reg == BK_RUN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            foreign_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            foreign_reg   <= foreign_next;
            fwd_valid_reg <= fwd_valid_next;
            if (pop) s1_valid_reg <= 1'b1;
            else if (s1_advance) s1_valid_reg <= 1'b0;
            if (load_out) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // payload registers and the histogram store
    always_ff @(posedge aclk) begin
        if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
        if (pop) begin
            s1_data_reg <= hist_mem[head_entry.addr];
            s1_op_reg   <= head_entry.op;
            s1_addr_reg <= head_entry.addr;
        end else if (s1_hold) begin
            // fold the forwarded value in while the op waits on the output
            s1_data_reg <= operand;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= inc_val;
        if (load_out) begin
            out_count_reg   <= RESULT_W'(operand);
            out_foreign_reg <= RESULT_W'(foreign_reg);
        end
    end

endmodule : kwh_back

`default_nettype wire

// ===== design/kmer_window_histogram_top.sv =====
// k-mer window histogram, top level
//
// channels: s_* takes one word per handshake, s_tuser selects the command
// (symbol, read, clear). m_* returns one word for each read command.
// cfg_* writes alphabet size, alphabet letters and window length, and is
// always ready; write it only while the block is idle.
// result path: a read result passes the work queue, the execute stage and
// the output register before it shows on m_tvalid, behind any queued work.
// throughput: one word per cycle while s_tready is high; each counted window
// costs one histogram read-modify-write, and back-to-back hits on one bin
// forward the last written value. a clear command sweeps the 4096-bin store
// one bin a cycle, with s_tready low throughout the sweep.
// reset: synchronous, active low; it restores the configuration defaults,
// empties the window and starts the same sweep of the store before the
// first word is taken.
// receiver stall: a result waits in the output register; the front keeps
// taking words until its four-entry queue fills, then drops s_tready.
// depends on kwh_pkg, kwh_front, kwh_queue, kwh_back
`default_nettype none

module kmer_window_histogram_top
    import kwh_pkg::*;
#(
    parameter int ALPHABET_MAX = ALPHABET_MAX_DEF,
    parameter int K_MAX        = K_MAX_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // symbol [7:0], read_index [19:8], zero [23:20]
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // cmd [1:0]
    input  wire logic [CMD_W-1:0]       s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // count [31:0], foreign_windows [63:32]
    output logic [M_TDATA_W-1:0]        m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    kwh_back_status_t  back_status;
    kwh_queue_status_t queue_status;
    logic              push, pop, head_valid;
    kwh_entry_t        push_entry, head_entry;

    kwh_front #(
        .ALPHABET_MAX(ALPHABET_MAX),
        .K_MAX       (K_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .back_status (back_status),
        .queue_status(queue_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    kwh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head_valid(head_valid),
        .head_entry(head_entry),
        .status    (queue_status)
    );

    kwh_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_entry(head_entry),
        .pop       (pop),
        .status    (back_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule : kmer_window_histogram_top

`default_nettype wire

// ===== design/kwh_checker.sv =====
// kwh_checker: port-level checks of the k-mer window histogram, bound to
// the top level; depends on kwh_pkg and kmer_window_histogram_top
`default_nettype none

module kwh_checker
    import kwh_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [S_TDATA_W-1:0]   s_tdata,
    input wire logic [CMD_W-1:0]       s_tuser,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_TDATA_W-1:0]   m_tdata,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // reset starts the store sweep, so no word is taken right after it
    a_sweep_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during the clearing sweep");

    // the sweep still holds s_tready low after reset has been released
    a_sweep_length: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !s_tready)
        else $error("clearing sweep ended too early");

    // no result can be pending right after reset
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word after reset");

endmodule : kwh_checker

bind kmer_window_histogram_top kwh_checker u_kwh_checker (.*);

`default_nettype wire

// ===== sim/tb_kmer_window_histogram_top.sv =====
// tb_kmer_window_histogram_top: self-checking bench for the k-mer window histogram
// runs a directed table and then random phases under changing alphabets and window lengths
// depends on kwh_pkg and kmer_window_histogram_top
`timescale 1ns / 1ps

module tb_kmer_window_histogram_top;
    import kwh_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int TIMEOUT_NS  = 12_000_000;
    localparam int IDLE_SETTLE = 16;
    localparam int DRAIN_LIMIT = 50_000;
    localparam int DIR_ROWS    = 25;
    localparam int PHASE_COUNT = 9;
    localparam int PHASE_WORDS = 90;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    typedef enum logic [1:0] {
        LET_RANDOM = 2'd0,
        LET_ZERO   = 2'd1,
        LET_ONES   = 2'd2,
        LET_DUP    = 2'd3
    } letter_mode_t;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] foreign;
    } read_result_t;

    typedef struct packed {
        bit                  is_cfg;
        kwh_cfg_t            reg_sel;
        logic [63:0]         reg_val;
        logic [CMD_W-1:0]    cmd;
        logic [7:0]          symbol;
        logic [WIN_BITS-1:0] index;
        bit                  typed;
        logic [31:0]         want_count;
        logic [31:0]         want_foreign;
    } dir_row_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        letter_mode_t      mode;
        logic [KLEN_W-1:0] klen;
        bit                wr_klen;
    } phase_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predicted block state
    logic [SIZE_W-1:0]   alpha_size;
    logic [63:0]         alpha_letters;
    logic [KLEN_W-1:0]   win_len;
    logic [WIN_BITS-1:0] win_codes;
    int                  letters_seen;
    int                  foreign_age;
    logic [31:0]         bin_count [BIN_COUNT];
    logic [31:0]         foreign_total;

    read_result_t read_results [$];
    int           mismatches = 0;
    int           burst_left = 0;
    bit           steady = 1'b0;
    logic [9:0]   stall_tick = '0;

    kmer_window_histogram_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int window_k();
        if (win_len == 0) return 1;
        if (win_len > K_MAX_DEF) return K_MAX_DEF;
        return int'(win_len);
    endfunction

    function automatic int alphabet_n();
        return (alpha_size > ALPHABET_MAX_DEF) ? ALPHABET_MAX_DEF : int'(alpha_size);
    endfunction

    function automatic bit is_blank(input logic [7:0] sym);
        return sym == BYTE_SPACE || (sym >= BYTE_TAB && sym <= BYTE_CR);
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    task automatic reset_window();
        win_codes    = '0;
        letters_seen = 0;
        foreign_age  = 0;
    endtask

    task automatic wipe_counts();
        int i;
        for (i = 0; i < BIN_COUNT; i++) bin_count[i] = '0;
        foreign_total = '0;
        reset_window();
    endtask

    task automatic tally_letter(input logic [7:0] sym);
        int k;
        int n;
        int i;
        int code;
        int mask;
        bit found;
        k = window_k();
        n = alphabet_n();
        code = 0;
        found = 1'b0;
        mask = (1 << (CODE_BITS * k)) - 1;
        for (i = 0; i < n; i++) begin
            if (!found && alpha_letters[8*i +: 8] == sym) begin
                code = i;
                found = 1'b1;
            end
        end
        win_codes = WIN_BITS'(((int'(win_codes) << CODE_BITS) | code) & mask);
        if (!found) foreign_age = k;
        if (letters_seen < K_MAX_DEF) letters_seen++;
        if (letters_seen >= k) begin
            if (foreign_age > 0) foreign_total = bump(foreign_total);
            else bin_count[win_codes] = bump(bin_count[win_codes]);
        end
        if (foreign_age > 0) foreign_age--;
    endtask

    task automatic apply_reg(input kwh_cfg_t sel, input logic [63:0] val);
        case (sel)
            CFG_SIZE: alpha_size = val[SIZE_W-1:0];
            CFG_LETTERS: alpha_letters = val;
            CFG_KLEN: begin
                win_len = val[KLEN_W-1:0];
                reset_window();
            end
            default: ;
        endcase
    endtask

    // hands one word to the block and updates the prediction once it is taken
    task automatic put_word(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
                            input logic [WIN_BITS-1:0] idx, input bit typed,
                            input logic [31:0] t_count, input logic [31:0] t_foreign);
        read_result_t res;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, idx, sym};
        do @(posedge aclk); while (!s_tready);
        case (cmd)
            CMD_SYMBOL: if (!is_blank(sym)) tally_letter(sym);
            CMD_READ: begin
                if (typed) begin
                    res.count   = t_count;
                    res.foreign = t_foreign;
                end else begin
                    res.count   = bin_count[idx];
                    res.foreign = foreign_total;
                end
                read_results.insert(read_results.size(), res);
            end
            CMD_CLEAR: wipe_counts();
            default: ;
        endcase
    endtask

    // bursts of random length, random gaps unless the phase runs steady
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (!steady) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end
        end
    endtask

    // no word pending, no result due and no clear sweep running
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (read_results.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input kwh_cfg_t sel, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(sel, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] make_letters(input letter_mode_t mode);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case (mode)
            LET_ZERO: v = '0;
            LET_ONES: v = '1;
            LET_DUP: begin
                v[15:8]  = v[7:0];
                v[39:32] = v[31:24];
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic dir_row_t word_row(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
                                          input logic [WIN_BITS-1:0] idx);
        dir_row_t r;
        r = '0;
        r.cmd = cmd;
        r.symbol = sym;
        r.index = idx;
        return r;
    endfunction

    function automatic dir_row_t read_row(input logic [WIN_BITS-1:0] idx,
                                          input logic [31:0] cnt, input logic [31:0] fgn);
        dir_row_t r;
        r = word_row(CMD_READ, 8'h00, idx);
        r.typed = 1'b1;
        r.want_count = cnt;
        r.want_foreign = fgn;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input kwh_cfg_t sel, input logic [63:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic phase_t mk_phase(input logic [SIZE_W-1:0] size, input letter_mode_t mode,
                                        input logic [KLEN_W-1:0] klen, input bit wr_klen);
        phase_t ph;
        ph.size = size;
        ph.mode = mode;
        ph.klen = klen;
        ph.wr_klen = wr_klen;
        return ph;
    endfunction

    always @(negedge aclk) begin
        stall_tick = stall_tick + 10'd1;
        case (stall_tick[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_tick[3:0] < 4'd5);
        endcase
    end

    always @(posedge aclk) begin
        read_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (read_results.size() == 0) begin
                $error("result word %h with no read outstanding", m_tdata);
                mismatches++;
            end else begin
                want = read_results.pop_front();
                if (m_tdata[31:0] !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[63:32] !== want.foreign) begin
                    $error("foreign_windows: expected %0d, got %0d",
                           want.foreign, m_tdata[63:32]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        dir_row_t    directed [DIR_ROWS];
        phase_t      phases [PHASE_COUNT];
        logic [63:0] noise;
        logic [CMD_W-1:0]    cmd;
        logic [7:0]          sym;
        logic [WIN_BITS-1:0] idx;
        int i;
        int p;
        int r;
        int n;
        int w;

        // default alphabet: letter codes 0..3 sit in bytes 0..3
        directed[0]  = read_row(12'd0, 32'd0, 32'd0);
        directed[1]  = read_row(12'hFFF, 32'd0, 32'd0);
        directed[2]  = word_row(CMD_SYMBOL, LETTERS_RESET[7:0], 12'hFFF);
        directed[3]  = word_row(CMD_SYMBOL, BYTE_SPACE, 12'd0);
        directed[4]  = word_row(CMD_SYMBOL, BYTE_TAB, 12'd0);
        directed[5]  = word_row(CMD_SYMBOL, BYTE_CR, 12'd0);
        directed[6]  = word_row(CMD_SYMBOL, LETTERS_RESET[31:24], 12'd0);
        directed[7]  = word_row(CMD_SYMBOL, 8'hFF, 12'd0);
        directed[8]  = word_row(CMD_SYMBOL, 8'h00, 12'd0);
        directed[9]  = word_row(CMD_READ, 8'hFF, 12'd0);
        directed[10] = word_row(CMD_READ, 8'h00, 12'd3);
        directed[11] = word_row(CMD_UNUSED, LETTERS_RESET[7:0], 12'd0);
        directed[12] = word_row(CMD_READ, 8'h00, 12'd0);
        directed[13] = word_row(CMD_CLEAR, 8'h00, 12'd0);
        directed[14] = read_row(12'd0, 32'd0, 32'd0);
        directed[15] = reg_row(CFG_KLEN, 64'd4);
        directed[16] = word_row(CMD_SYMBOL, LETTERS_RESET[7:0], 12'd0);
        directed[17] = word_row(CMD_SYMBOL, LETTERS_RESET[15:8], 12'd0);
        directed[18] = word_row(CMD_SYMBOL, LETTERS_RESET[23:16], 12'd0);
        // three letters into a four-letter window count nothing
        directed[19] = read_row(12'o0012, 32'd0, 32'd0);
        directed[20] = word_row(CMD_SYMBOL, LETTERS_RESET[31:24], 12'd0);
        directed[21] = word_row(CMD_READ, 8'h00, 12'o0123);
        directed[22] = word_row(CMD_SYMBOL, 8'hFF, 12'd0);
        directed[23] = word_row(CMD_READ, 8'h00, 12'd0);
        directed[24] = reg_row(CFG_KLEN, 64'd1);

        phases[0] = mk_phase(4'd8,  LET_RANDOM, 3'd4, 1'b1);
        phases[1] = mk_phase(4'd1,  LET_RANDOM, 3'd2, 1'b1);
        phases[2] = mk_phase(4'd0,  LET_RANDOM, 3'd3, 1'b1);
        phases[3] = mk_phase(4'd15, LET_DUP,    3'd7, 1'b1);
        phases[4] = mk_phase(4'd3,  LET_ZERO,   3'd0, 1'b1);
        phases[5] = mk_phase(4'd8,  LET_ONES,   3'd5, 1'b1);
        phases[6] = mk_phase(4'd2,  LET_RANDOM, 3'd1, 1'b0);
        phases[7] = mk_phase(4'd5,  LET_DUP,    3'd4, 1'b0);
        phases[8] = mk_phase(4'd8,  LET_RANDOM, 3'd3, 1'b1);

        alpha_size    = SIZE_RESET;
        alpha_letters = LETTERS_RESET;
        win_len       = KLEN_RESET;
        wipe_counts();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            if (directed[i].is_cfg) begin
                wait_idle();
                cfg_write(directed[i].reg_sel, directed[i].reg_val);
            end else begin
                put_word(directed[i].cmd, directed[i].symbol, directed[i].index,
                         directed[i].typed, directed[i].want_count, directed[i].want_foreign);
                pace();
            end
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            wait_idle();
            noise = {$urandom, $urandom};
            cfg_write(CFG_SIZE, {noise[63:SIZE_W], phases[p].size});
            cfg_write(CFG_LETTERS, make_letters(phases[p].mode));
            if (phases[p].wr_klen) cfg_write(CFG_KLEN, {noise[63:KLEN_W], phases[p].klen});
            steady = ($urandom_range(0, 3) == 0);
            for (w = 0; w < PHASE_WORDS; w++) begin
                r   = $urandom_range(0, 999);
                sym = 8'($urandom);
                idx = WIN_BITS'($urandom);
                if (r < 700) begin
                    cmd = CMD_SYMBOL;
                    n = alphabet_n();
                    if (n > 0) sym = alpha_letters[8*$urandom_range(0, n - 1) +: 8];
                end else if (r < 780) begin
                    cmd = CMD_SYMBOL;
                end else if (r < 830) begin
                    cmd = CMD_SYMBOL;
                    n = $urandom_range(0, 5);
                    sym = (n == 5) ? BYTE_SPACE : BYTE_TAB + 8'(n);
                end else if (r < 975) begin
                    cmd = CMD_READ;
                    // half the reads hit the bin of the current window
                    if ($urandom_range(0, 1) == 0) idx = win_codes;
                end else if (r < 990) begin
                    cmd = CMD_UNUSED;
                end else begin
                    cmd = CMD_CLEAR;
                end
                put_word(cmd, sym, idx, 1'b0, 32'd0, 32'd0);
                pace();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && read_results.size() != 0; w++) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (read_results.size() != 0) begin
            $error("%0d read results never arrived", read_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
design/kwh_pkg.sv
design/kwh_front.sv
design/kwh_queue.sv
design/kwh_back.sv
design/kmer_window_histogram_top.sv
design/kwh_checker.sv
sim/tb_kmer_window_histogram_top.sv
